### rtl/mals_pkg.sv
`timescale 1ns / 1ps
package mals_pkg;
	localparam int MAX_SIDE = 256;
	localparam int MAX_ANTS = 64;
	localparam int CELL_AW = 16;

	localparam logic [1:0] KIND_TOGGLE = 2'd0;
	localparam logic [1:0] KIND_ROTATE = 2'd1;
	localparam logic [1:0] KIND_ADVANCE = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] col_x;
		logic [7:0] row_y;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] generation;
		logic [16:0] marked_cells;
		logic [6:0] ant_total;
	} rsp_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load_req;      // capture request
		logic clr_step;      // clear one grid cell (clearing pass)
		logic scan_start;    // reset scan index and ant index to 0
		logic scan_next;     // advance scan index
		logic ant_rd;        // issue ant table read at ant index
		logic cell_rd;       // issue cell read for current ant
		logic cell_wr;       // flip cell, update heading, mark count
		logic occ_start;     // start occupancy scan for target
		logic occ_next;      // step occupancy scan
		logic ant_move;      // commit move if free
		logic ant_next;      // next ant
		logic add_ant;
		logic rot_ant;
		logic shift_step;    // copy entry at scan index down by one
		logic del_done;      // decrement count
		logic gen_inc;
		logic set_status_full;
		logic set_status_range;
		logic set_status_done;
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic clr_last;
		logic in_range;
		logic scan_end;      // scan index reached ant count
		logic scan_hit;      // entry at scan index matches key
		logic list_full;
		logic ants_end;      // ant index reached count
		logic occ_end;
		logic occ_hit;
	} sts_t;
endpackage

### rtl/mals_stream_if.sv
`timescale 1ns / 1ps
interface mals_req_if;
	logic valid;
	logic ready;
	mals_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface mals_rsp_if;
	logic valid;
	logic ready;
	mals_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/mals_datapath.sv
`timescale 1ns / 1ps
module mals_datapath (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [8:0] cfg_data,
	input  mals_pkg::req_t req,
	input  mals_pkg::cmd_t cmd,
	output mals_pkg::sts_t sts,
	output mals_pkg::rsp_t rsp
);
	// configuration
	logic [8:0] grid_side_q;
	logic [8:0] side;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) grid_side_q <= 9'd256;
		else if (cfg_we) grid_side_q <= cfg_data;
	end
	always_comb begin
		side = grid_side_q;
		if (side < 9'd2) side = 9'd2;
		if (side > 9'(mals_pkg::MAX_SIDE)) side = 9'(mals_pkg::MAX_SIDE);
	end

	// captured request
	mals_pkg::req_t req_q;
	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= req;
	end
	assign sts.in_range = ({1'b0, req_q.col_x} < side) && ({1'b0, req_q.row_y} < side);

	// ant table: small register file, few ports
	logic [7:0] ant_col_q [mals_pkg::MAX_ANTS];
	logic [7:0] ant_row_q [mals_pkg::MAX_ANTS];
	logic [1:0] ant_hd_q [mals_pkg::MAX_ANTS];
	logic [6:0] ant_cnt_q;
	logic [31:0] gen_q;
	logic [16:0] mark_q;
	logic [1:0] status_q;

	// scan index (search / shift / occupancy) and ant index (generation)
	logic [6:0] scan_q;
	logic [6:0] ai_q;
	logic [5:0] scan_a, scan_am1, ai_a;
	assign scan_a = scan_q[5:0];
	assign scan_am1 = scan_a - 6'd1;
	assign ai_a = ai_q[5:0];

	// registered reads of the tables
	logic [7:0] sc_col_s1, sc_row_s1;
	logic [1:0] sc_hd_s1;
	logic [7:0] cur_col_q, cur_row_q, nc_q, nr_q;
	logic [1:0] cur_hd_q;
	always_ff @(posedge clk) begin
		sc_col_s1 <= ant_col_q[scan_a];
		sc_row_s1 <= ant_row_q[scan_a];
		sc_hd_s1 <= ant_hd_q[scan_a];
	end
	logic scan_vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_q <= 1'b0;
		end else begin
			scan_vld_q <= cmd.scan_start | cmd.scan_next | cmd.occ_start | cmd.occ_next;
		end
	end
	assign sts.scan_end = (scan_q >= ant_cnt_q) || scan_q[6];
	assign sts.scan_hit = !sts.scan_end && (sc_col_s1 == req_q.col_x)
		&& (sc_row_s1 == req_q.row_y) && !scan_vld_q;
	assign sts.list_full = (ant_cnt_q >= 7'(mals_pkg::MAX_ANTS));
	assign sts.ants_end = (ai_q >= ant_cnt_q) || ai_q[6];
	assign sts.occ_end = sts.scan_end;
	assign sts.occ_hit = !sts.scan_end && !scan_vld_q
		&& (sc_col_s1 == nc_q) && (sc_row_s1 == nr_q);

	// grid memory, one cell per word
	logic [mals_pkg::CELL_AW-1:0] cell_addr;
	logic [7:0] clr_q;
	logic [7:0] clr_col_q;
	logic cell_s1;
	logic mem_q [2**mals_pkg::CELL_AW];
	assign cell_addr = {cur_row_q, cur_col_q};
	assign sts.clr_last = (clr_q == 8'hff) && (clr_col_q == 8'hff);
	always_ff @(posedge clk) begin
		if (cmd.clr_step) mem_q[{clr_q, clr_col_q}] <= 1'b0;
		else if (cmd.cell_wr) mem_q[cell_addr] <= ~cell_s1;
		if (cmd.cell_rd) cell_s1 <= mem_q[cell_addr];
	end
	// clearing sweep counter: one cell per cycle
	logic [15:0] clr_n;
	assign clr_n = {clr_q, clr_col_q} + 16'd1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			clr_col_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_n[15:8];
			clr_col_q <= clr_n[7:0];
		end
	end

	// next heading and target
	logic [1:0] nh;
	logic [7:0] nc, nr;
	logic [8:0] cu, ru;
	always_comb begin
		nh = cell_s1 ? 2'(cur_hd_q + 2'd1) : 2'(cur_hd_q + 2'd3);
		cu = {1'b0, cur_col_q} + 9'd1;
		ru = {1'b0, cur_row_q} + 9'd1;
		nc = cur_col_q;
		nr = cur_row_q;
		case (nh)
			2'd0: nr = (ru >= side) ? 8'd0 : ru[7:0];
			2'd1: nc = (cu >= side) ? 8'd0 : cu[7:0];
			2'd2: nr = (cur_row_q == 8'd0) ? 8'(side - 9'd1) : 8'(cur_row_q - 8'd1);
			default: nc = (cur_col_q == 8'd0) ? 8'(side - 9'd1) : 8'(cur_col_q - 8'd1);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.ant_rd) begin
			cur_col_q <= ant_col_q[ai_a];
			cur_row_q <= ant_row_q[ai_a];
			cur_hd_q <= ant_hd_q[ai_a];
		end
		if (cmd.cell_wr) begin
			nc_q <= nc;
			nr_q <= nr;
			cur_hd_q <= nh;
		end
	end

	// ant table writes
	always_ff @(posedge clk) begin
		if (cmd.add_ant) begin
			ant_col_q[ant_cnt_q[5:0]] <= req_q.col_x;
			ant_row_q[ant_cnt_q[5:0]] <= req_q.row_y;
			ant_hd_q[ant_cnt_q[5:0]] <= 2'd0;
		end else if (cmd.rot_ant) begin
			ant_hd_q[scan_a] <= 2'(sc_hd_s1 + 2'd3);
		end else if (cmd.shift_step) begin
			ant_col_q[scan_am1] <= sc_col_s1;
			ant_row_q[scan_am1] <= sc_row_s1;
			ant_hd_q[scan_am1] <= sc_hd_s1;
		end else if (cmd.cell_wr) begin
			ant_hd_q[ai_a] <= nh;
		end else if (cmd.ant_move) begin
			ant_col_q[ai_a] <= nc_q;
			ant_row_q[ai_a] <= nr_q;
		end
	end

	// counters and indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ant_cnt_q <= '0;
			gen_q <= '0;
			mark_q <= '0;
			status_q <= mals_pkg::ST_DONE;
			scan_q <= '0;
			ai_q <= '0;
		end else begin
			if (cmd.add_ant) ant_cnt_q <= ant_cnt_q + 7'd1;
			if (cmd.del_done) ant_cnt_q <= ant_cnt_q - 7'd1;
			if (cmd.gen_inc) gen_q <= gen_q + 32'd1;
			if (cmd.cell_wr) mark_q <= cell_s1 ? mark_q - 17'd1 : mark_q + 17'd1;
			if (cmd.set_status_full) status_q <= mals_pkg::ST_FULL;
			else if (cmd.set_status_range) status_q <= mals_pkg::ST_RANGE;
			else if (cmd.set_status_done) status_q <= mals_pkg::ST_DONE;
			if (cmd.scan_start || cmd.occ_start) scan_q <= '0;
			else if (cmd.scan_next || cmd.occ_next || cmd.shift_step) scan_q <= scan_q + 7'd1;
			if (cmd.scan_start) ai_q <= '0;
			else if (cmd.ant_next) ai_q <= ai_q + 7'd1;
		end
	end

	assign rsp.status = status_q;
	assign rsp.generation = gen_q;
	assign rsp.marked_cells = mark_q;
	assign rsp.ant_total = ant_cnt_q;
endmodule

### rtl/mals_ctrl.sv
`timescale 1ns / 1ps
module mals_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  mals_pkg::req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  mals_pkg::sts_t sts,
	output mals_pkg::cmd_t cmd
);
	localparam logic [3:0] S_CLR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_DEC = 4'd2;
	localparam logic [3:0] S_SCAN = 4'd3;
	localparam logic [3:0] S_SHIFT = 4'd4;
	localparam logic [3:0] S_ANT = 4'd5;
	localparam logic [3:0] S_RD = 4'd6;
	localparam logic [3:0] S_FLIP = 4'd7;
	localparam logic [3:0] S_OCC = 4'd8;
	localparam logic [3:0] S_MOVE = 4'd9;
	localparam logic [3:0] S_OUT = 4'd10;
	localparam logic [3:0] S_WAIT = 4'd11;
	localparam logic [3:0] S_CELL = 4'd12;
	localparam logic [3:0] S_OWAIT = 4'd13;
	localparam logic [3:0] S_SWAIT = 4'd14;

	logic [3:0] state_q, state_d;
	logic [1:0] kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			kind_q <= mals_pkg::KIND_TOGGLE;
		end else begin
			state_q <= state_d;
			if (req_valid && req_ready) kind_q <= req.kind;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_OUT);

	// scan reads are registered: S_SCAN alternates with S_WAIT
	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				cmd.set_status_done = 1'b1;
				cmd.scan_start = 1'b1;
				if (kind_q == mals_pkg::KIND_ADVANCE) state_d = S_ANT;
				else if (kind_q == mals_pkg::KIND_TOGGLE || kind_q == mals_pkg::KIND_ROTATE) begin
					if (!sts.in_range) begin
						cmd.set_status_range = 1'b1;
						state_d = S_OUT;
					end else state_d = S_WAIT;
				end else state_d = S_OUT;
			end
			S_WAIT: state_d = S_SCAN;
			S_SCAN: begin
				if (sts.scan_end) begin
					if (kind_q == mals_pkg::KIND_TOGGLE) begin
						if (sts.list_full) cmd.set_status_full = 1'b1;
						else cmd.add_ant = 1'b1;
					end
					state_d = S_OUT;
				end else if (sts.scan_hit) begin
					if (kind_q == mals_pkg::KIND_ROTATE) begin
						cmd.rot_ant = 1'b1;
						state_d = S_OUT;
					end else begin
						// erase: read the next entry, then move entries down
						cmd.scan_next = 1'b1;
						state_d = S_SWAIT;
					end
				end else begin
					cmd.scan_next = 1'b1;
					state_d = S_WAIT;
				end
			end
			S_SWAIT: state_d = S_SHIFT;
			S_SHIFT: begin
				if (sts.scan_end) begin
					cmd.del_done = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.shift_step = 1'b1;
					state_d = S_SWAIT;
				end
			end
			S_ANT: begin
				if (sts.ants_end) begin
					cmd.gen_inc = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.ant_rd = 1'b1;
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.cell_rd = 1'b1;
				state_d = S_CELL;
			end
			S_CELL: state_d = S_FLIP;
			S_FLIP: begin
				cmd.cell_wr = 1'b1;
				cmd.occ_start = 1'b1;
				state_d = S_OWAIT;
			end
			S_OWAIT: state_d = S_OCC;
			S_OCC: begin
				if (sts.occ_end) state_d = S_MOVE;
				else if (sts.occ_hit) begin
					cmd.ant_next = 1'b1;
					state_d = S_ANT;
				end else begin
					cmd.occ_next = 1'b1;
					state_d = S_OWAIT;
				end
			end
			S_MOVE: begin
				cmd.ant_move = 1'b1;
				cmd.ant_next = 1'b1;
				state_d = S_ANT;
			end
			S_OUT: if (rsp_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end
endmodule

### rtl/multi_ant_langton_step_unit.sv
`timescale 1ns / 1ps
// One request at a time; the next can be taken in the cycle after the response is accepted.
// Reset: the grid memory is cleared by a sweep over all cells, one cell per cycle;
// no request is taken until it ends. Counters clear at once, grid_side resets to 256.
module multi_ant_langton_step_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [8:0] cfg_data,
	mals_req_if.sink req_ch,
	mals_rsp_if.source rsp_ch
);
	mals_pkg::cmd_t cmd;
	mals_pkg::sts_t sts;
	mals_pkg::rsp_t rsp;

	mals_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_ch.valid), .req_ready(req_ch.ready), .req(req_ch.payload),
		.rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	mals_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.req(req_ch.payload), .cmd(cmd), .sts(sts), .rsp(rsp)
	);

	assign rsp_ch.payload = rsp;

	// no request accepted while a response is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ch.valid |-> !req_ch.ready) else $error("overlap");
	// ant count never exceeds the table
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.ant_total <= 7'(mals_pkg::MAX_ANTS)) else $error("ant count");
	// generation moves only by one
	a_gen: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.generation != $past(rsp.generation)) |->
		(rsp.generation == $past(rsp.generation) + 32'd1)) else $error("gen");
endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	// kind code with no operation
	localparam logic [1:0] KIND_NONE = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [8:0] cfg_data;

	mals_req_if req_ch ();
	mals_rsp_if rsp_ch ();

	multi_ant_langton_step_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req_ch(req_ch.sink),
		.rsp_ch(rsp_ch.source)
	);

	// grid shadow state
	bit grid [0:65535];
	bit [7:0] ant_x [0:mals_pkg::MAX_ANTS-1];
	bit [7:0] ant_y [0:mals_pkg::MAX_ANTS-1];
	bit [1:0] ant_dir [0:mals_pkg::MAX_ANTS-1];
	int ants;
	bit [31:0] gens;
	bit [16:0] marks;
	bit [8:0] side_reg;

	mals_pkg::rsp_t pending_rsp [$];
	int errors;
	int sent;
	int received;
	int src_idle_pct;
	int snk_stall_pct;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int side_now();
		int s;
		s = side_reg;
		if (s < 2) s = 2;
		if (s > mals_pkg::MAX_SIDE) s = mals_pkg::MAX_SIDE;
		return s;
	endfunction

	function automatic int ant_at(int x, int y);
		for (int i = 0; i < ants; i++)
			if (ant_x[i] == x && ant_y[i] == y) return i;
		return -1;
	endfunction

	// one generation over the ant list, in list order
	function automatic void walk_ants();
		int s;
		int a;
		int nx;
		int ny;
		s = side_now();
		for (int i = 0; i < ants; i++) begin
			a = ant_y[i] * 256 + ant_x[i];
			if (grid[a]) begin
				ant_dir[i] = ant_dir[i] + 2'd1;
				grid[a] = 0;
				marks = marks - 17'd1;
			end else begin
				ant_dir[i] = ant_dir[i] + 2'd3;
				grid[a] = 1;
				marks = marks + 17'd1;
			end
			nx = ant_x[i];
			ny = ant_y[i];
			case (ant_dir[i])
				2'd0: ny = (ny + 1 >= s) ? 0 : ny + 1;
				2'd1: nx = (nx + 1 >= s) ? 0 : nx + 1;
				2'd2: ny = (ny == 0) ? s - 1 : ny - 1;
				default: nx = (nx == 0) ? s - 1 : nx - 1;
			endcase
			if (ant_at(nx, ny) < 0) begin
				ant_x[i] = 8'(nx);
				ant_y[i] = 8'(ny);
			end
		end
		gens = gens + 32'd1;
	endfunction

	function automatic mals_pkg::rsp_t predict_counters(mals_pkg::req_t r);
		mals_pkg::rsp_t o;
		int k;
		o.status = mals_pkg::ST_DONE;
		if (r.kind == mals_pkg::KIND_TOGGLE || r.kind == mals_pkg::KIND_ROTATE) begin
			if (r.col_x >= side_now() || r.row_y >= side_now()) begin
				o.status = mals_pkg::ST_RANGE;
			end else begin
				k = ant_at(r.col_x, r.row_y);
				if (r.kind == mals_pkg::KIND_ROTATE) begin
					if (k >= 0) ant_dir[k] = ant_dir[k] + 2'd3;
				end else if (k >= 0) begin
					for (int j = k; j + 1 < ants; j++) begin
						ant_x[j] = ant_x[j+1];
						ant_y[j] = ant_y[j+1];
						ant_dir[j] = ant_dir[j+1];
					end
					ants--;
				end else if (ants >= mals_pkg::MAX_ANTS) begin
					o.status = mals_pkg::ST_FULL;
				end else begin
					ant_x[ants] = r.col_x;
					ant_y[ants] = r.row_y;
					ant_dir[ants] = 2'd0;
					ants++;
				end
			end
		end else if (r.kind == mals_pkg::KIND_ADVANCE) begin
			walk_ants();
		end
		o.generation = gens;
		o.marked_cells = marks;
		o.ant_total = ants[6:0];
		return o;
	endfunction

	task automatic send_request(bit [1:0] kind, bit [7:0] x, bit [7:0] y);
		mals_pkg::req_t r;
		r.kind = kind;
		r.col_x = x;
		r.row_y = y;
		while ($urandom_range(99) < src_idle_pct) @(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.payload <= r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_rsp.insert(pending_rsp.size(), predict_counters(r));
		sent++;
		@(negedge clk);
		req_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// response checker
	always @(posedge clk) begin
		mals_pkg::rsp_t exp_r;
		if (rsp_ch.valid && rsp_ch.ready) begin
			received++;
			if (pending_rsp.size() == 0) begin
				$error("response with nothing expected");
				errors++;
			end else begin
				exp_r = pending_rsp.pop_front();
				if (rsp_ch.payload.status !== exp_r.status) begin
					$error("status exp %0d got %0d", exp_r.status, rsp_ch.payload.status);
					errors++;
				end
				if (rsp_ch.payload.generation !== exp_r.generation) begin
					$error("generation exp %0d got %0d", exp_r.generation,
						rsp_ch.payload.generation);
					errors++;
				end
				if (rsp_ch.payload.marked_cells !== exp_r.marked_cells) begin
					$error("marked_cells exp %0d got %0d", exp_r.marked_cells,
						rsp_ch.payload.marked_cells);
					errors++;
				end
				if (rsp_ch.payload.ant_total !== exp_r.ant_total) begin
					$error("ant_total exp %0d got %0d", exp_r.ant_total,
						rsp_ch.payload.ant_total);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	task automatic drain();
		while (pending_rsp.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_side(bit [8:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		side_reg = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed();
		write_side(9'd256);
		send_request(mals_pkg::KIND_ADVANCE, 8'hff, 8'hff);
		send_request(mals_pkg::KIND_TOGGLE, 8'd0, 8'd0);
		send_request(mals_pkg::KIND_TOGGLE, 8'd255, 8'd255);
		send_request(mals_pkg::KIND_TOGGLE, 8'd255, 8'd0);
		send_request(mals_pkg::KIND_ROTATE, 8'd0, 8'd0);
		send_request(mals_pkg::KIND_ROTATE, 8'd5, 8'd5);
		send_request(KIND_NONE, 8'd1, 8'd1);
		send_request(mals_pkg::KIND_ADVANCE, 8'd0, 8'd0);
		send_request(mals_pkg::KIND_ADVANCE, 8'd0, 8'd0);
		send_request(mals_pkg::KIND_TOGGLE, 8'd0, 8'd0);
		send_request(mals_pkg::KIND_ADVANCE, 8'd0, 8'd0);
		// shrink with ants and marks outside the grid
		write_side(9'd2);
		send_request(mals_pkg::KIND_TOGGLE, 8'd2, 8'd0);
		send_request(mals_pkg::KIND_ROTATE, 8'd0, 8'd2);
		send_request(mals_pkg::KIND_TOGGLE, 8'd1, 8'd1);
		send_request(mals_pkg::KIND_ADVANCE, 8'd0, 8'd0);
		send_request(mals_pkg::KIND_ADVANCE, 8'd0, 8'd0);
		// side below minimum and above maximum clamp
		write_side(9'd0);
		send_request(mals_pkg::KIND_TOGGLE, 8'd1, 8'd0);
		send_request(mals_pkg::KIND_ADVANCE, 8'd0, 8'd0);
		write_side(9'h1ff);
		send_request(mals_pkg::KIND_TOGGLE, 8'd200, 8'd100);
		send_request(mals_pkg::KIND_ADVANCE, 8'd0, 8'd0);
	endtask

	// fill the ant list to overflow on a small grid
	task automatic test_list_full();
		write_side(9'd16);
		while (ants < mals_pkg::MAX_ANTS)
			send_request(mals_pkg::KIND_TOGGLE, 8'($urandom_range(15)),
				8'($urandom_range(15)));
		send_request(mals_pkg::KIND_TOGGLE, 8'd15, 8'd15);
		send_request(mals_pkg::KIND_ADVANCE, 8'd0, 8'd0);
		for (int i = 0; i < 40; i++)
			send_request(mals_pkg::KIND_TOGGLE, 8'($urandom_range(15)),
				8'($urandom_range(15)));
	endtask

	task automatic test_random(int count, bit [8:0] side);
		int s;
		int p;
		write_side(side);
		s = side_now();
		for (int i = 0; i < count; i++) begin
			p = $urandom_range(99);
			if (p < 45)
				send_request(mals_pkg::KIND_ADVANCE, 8'($urandom), 8'($urandom));
			else if (p < 75)
				send_request(mals_pkg::KIND_TOGGLE, 8'($urandom_range(s - 1)),
					8'($urandom_range(s - 1)));
			else if (p < 92)
				send_request(mals_pkg::KIND_ROTATE, 8'($urandom_range(s - 1)),
					8'($urandom_range(s - 1)));
			else
				send_request(2'($urandom_range(3)), 8'($urandom), 8'($urandom));
			// remove ants now and then so the list does not stay full
			if (ants > 48 && $urandom_range(3) == 0)
				send_request(mals_pkg::KIND_TOGGLE, ant_x[0], ant_y[0]);
		end
	endtask

	initial begin
		errors = 0;
		sent = 0;
		received = 0;
		ants = 0;
		gens = 0;
		marks = 0;
		side_reg = 9'd256;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		cfg_we = 1'b0;
		cfg_data = 9'd0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_list_full();
		test_random(270, 9'd8);
		src_idle_pct = 57;
		test_random(220, 9'd3);
		// hold off until all responses are back
		drain();
		src_idle_pct = 0;
		snk_stall_pct = 57;
		test_random(220, 9'd256);
		src_idle_pct = 32;
		snk_stall_pct = 32;
		test_random(220, 9'd37);
		src_idle_pct = 0;
		snk_stall_pct = 0;
		test_random(120, 9'd2);
		drain();
		$display("Sent %0d requests, checked %0d responses over several grid sides,",
			sent, received);
		$display("including a full ant list, clamped sides and shrunken grids.");
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// run limit, covering the reset clearing sweep and full-list generations
	initial begin
		#500ms;
		$display("Some tests failed");
		$finish;
	end
endmodule
